// ----- rtl/msp_frame_parser_unit_assert.svh -----
// Assertion macros for the MSP frame parser.
// Each macro checks a property on the rising clock edge and is disabled
// while the active-low reset is asserted.
`ifndef MSP_FRAME_PARSER_UNIT_ASSERT_SVH
`define MSP_FRAME_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define MSP_FP_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define MSP_FP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MSP_FP_ASSERT_NOW(name, clk, rstn, ante, cons, msg)

`define MSP_FP_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/msp_fp_pkg.sv -----
`default_nettype none

package msp_fp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'd0,
        ST_VER     = 4'd1,
        ST_DIR     = 4'd2,
        ST_SIZE1   = 4'd3,
        ST_CMD1    = 4'd4,
        ST_PAYLOAD = 4'd5,
        ST_CHECK   = 4'd6,
        ST_FLAG2   = 4'd7,
        ST_CMDL2   = 4'd8,
        ST_CMDH2   = 4'd9,
        ST_SIZEL2  = 4'd10,
        ST_SIZEH2  = 4'd11
    } parse_state_t;

    localparam logic [2:0] STATUS_PROGRESS = 3'd0;
    localparam logic [2:0] STATUS_HEADER   = 3'd1;
    localparam logic [2:0] STATUS_LENGTH   = 3'd2;
    localparam logic [2:0] STATUS_CHECKSUM = 3'd3;
    localparam logic [2:0] STATUS_GOOD     = 3'd4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [7:0] CRC_POLY  = 8'hD5;

    typedef struct packed {
        logic [2:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [15:0] command;
        logic [15:0] length;
        logic        direction;
        logic        version;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/msp_fp_if.sv -----
`default_nettype none

interface msp_fp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_fp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [15:0] command;
    logic [15:0] length;
    logic        direction;
    logic        version;

    modport source (
        output valid, output status, output payload_valid, output payload_byte,
        output payload_index, output command, output length, output direction,
        output version, input ready
    );
    modport sink (
        input valid, input status, input payload_valid, input payload_byte,
        input payload_index, input command, input length, input direction,
        input version, output ready
    );
endinterface

`default_nettype wire

// ----- rtl/msp_fp_crc8.sv -----
`default_nettype none

module msp_fp_crc8 (
    input  wire logic [7:0] crc,
    input  wire logic [7:0] data,
    output logic      [7:0] crc_out
);
    import msp_fp_pkg::*;

    logic [7:0] c;

    // one bit per step, MSB first
    always_comb
    begin
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ----- rtl/msp_frame_parser_unit.sv -----
// MSP v1/v2 frame parser.
// rx: one received serial byte per transaction (valid/ready, field rx_byte).
// parsed: one result transaction per accepted byte, carrying status, the
//   payload byte with its index when the byte belongs to the payload, and the
//   command, length, direction and version of the frame being parsed.
// Output: the result of a byte is in the output register in the cycle after
//   the byte is accepted. Throughput: one byte per cycle unless stalled, set
//   by the single state update (header decode, XOR or one byte-wide CRC-8
//   step) between the parser state registers and the output register.
// Stall: rx.ready is high while the output register is empty or being taken
//   in the same cycle; while the receiver holds parsed.ready low with a result
//   waiting, hold the result and take no new byte.
// Reset: parser returns to idle, all frame fields and the running check
//   clear, and the output register empties.
// Errors (bad start, version, direction or v2 flag; v2 size above
//   MAX_PAYLOAD_V2; checksum mismatch) report their status and drop back to
//   idle. A good frame reports status good with its fields, then clears all but the version.

`include "msp_frame_parser_unit_assert.svh"

`default_nettype none

module msp_frame_parser_unit #(
    parameter int MAX_PAYLOAD_V2 = 256
) (
    input wire logic clk,
    input wire logic rst_n,
    msp_fp_in_if.sink    rx,
    msp_fp_out_if.source parsed
);
    import msp_fp_pkg::*;

    localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD_V2);

    parse_state_t state_reg, state_next;
    logic         ver_reg, ver_next;
    logic         dir_reg, dir_next, dir_upd;
    logic [15:0]  cmd_reg, cmd_next, cmd_upd;
    logic [15:0]  len_reg, len_next, len_upd;
    logic [7:0]   check_reg, check_next, check_upd;
    logic [15:0]  cnt_reg, cnt_next;
    logic [15:0]  cnt_inc;
    logic [15:0]  len_v2;
    logic [7:0]   crc_out;
    logic [7:0]   b;
    logic         good;
    logic         accept;

    result_t      res_reg, res_next;
    logic         out_valid_reg, out_valid_next;

    assign b      = rx.rx_byte;
    assign rx.ready = !out_valid_reg || parsed.ready;
    assign accept = rx.valid && rx.ready;

    msp_fp_crc8 u_crc (
        .crc     (check_reg),
        .data    (b),
        .crc_out (crc_out)
    );

    assign cnt_inc = cnt_reg + 16'd1;
    assign len_v2  = {b, len_reg[7:0]};

    // Parser state update and result for the byte at the input.
    always_comb
    begin
        state_next = state_reg;
        ver_next   = ver_reg;
        dir_upd    = dir_reg;
        cmd_upd    = cmd_reg;
        len_upd    = len_reg;
        check_upd  = check_reg;
        cnt_next   = cnt_reg;
        good       = 1'b0;
        res_next   = '0;
        res_next.status = STATUS_PROGRESS;

        unique case (state_reg)
            ST_VER:
            begin
                if (b == CH_M)
                begin
                    ver_next   = 1'b0;
                    state_next = ST_DIR;
                end
                else if (b == CH_X)
                begin
                    ver_next   = 1'b1;
                    state_next = ST_DIR;
                end
                else
                begin
                    state_next      = ST_IDLE;
                    res_next.status = STATUS_HEADER;
                end
            end
            ST_DIR:
            begin
                if (b == CH_LT || b == CH_GT)
                begin
                    dir_upd    = (b == CH_GT);
                    state_next = ver_reg ? ST_FLAG2 : ST_SIZE1;
                end
                else
                begin
                    state_next      = ST_IDLE;
                    res_next.status = STATUS_HEADER;
                end
            end
            ST_SIZE1:
            begin
                check_upd  = b;
                len_upd    = {8'h00, b};
                state_next = ST_CMD1;
            end
            ST_CMD1:
            begin
                cmd_upd    = {8'h00, b};
                check_upd  = check_reg ^ b;
                cnt_next   = '0;
                state_next = (len_reg != '0) ? ST_PAYLOAD : ST_CHECK;
            end
            ST_PAYLOAD:
            begin
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = b;
                res_next.payload_index = cnt_reg;
                check_upd = ver_reg ? crc_out : (check_reg ^ b);
                if (cnt_inc == len_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_IDLE;
                if (check_reg == b)
                begin
                    good            = 1'b1;
                    res_next.status = STATUS_GOOD;
                end
                else
                begin
                    res_next.status = STATUS_CHECKSUM;
                end
            end
            ST_FLAG2:
            begin
                if (b != 8'h00)
                begin
                    state_next      = ST_IDLE;
                    res_next.status = STATUS_HEADER;
                end
                else
                begin
                    // CRC of a zero byte from a zero seed stays zero
                    check_upd  = '0;
                    state_next = ST_CMDL2;
                end
            end
            ST_CMDL2:
            begin
                cmd_upd    = {8'h00, b};
                check_upd  = crc_out;
                state_next = ST_CMDH2;
            end
            ST_CMDH2:
            begin
                cmd_upd    = {b, cmd_reg[7:0]};
                check_upd  = crc_out;
                state_next = ST_SIZEL2;
            end
            ST_SIZEL2:
            begin
                len_upd    = {8'h00, b};
                check_upd  = crc_out;
                state_next = ST_SIZEH2;
            end
            ST_SIZEH2:
            begin
                len_upd = len_v2;
                if (len_v2 > MAX_LEN)
                begin
                    state_next      = ST_IDLE;
                    res_next.status = STATUS_LENGTH;
                end
                else
                begin
                    check_upd  = crc_out;
                    cnt_next   = '0;
                    state_next = (len_v2 != '0) ? ST_PAYLOAD : ST_CHECK;
                end
            end
            default:
            begin
                // idle and any unused code: wait for the start byte
                if (b == CH_DOLLAR)
                begin
                    state_next = ST_VER;
                end
                else
                begin
                    state_next      = ST_IDLE;
                    res_next.status = STATUS_HEADER;
                end
            end
        endcase

        // report the frame as it stands after this byte
        res_next.command   = cmd_upd;
        res_next.length    = len_upd;
        res_next.direction = dir_upd;
        res_next.version   = ver_next;

        // a good frame clears command, length, direction and check once reported
        cmd_next   = good ? '0 : cmd_upd;
        len_next   = good ? '0 : len_upd;
        dir_next   = good ? 1'b0 : dir_upd;
        check_next = good ? '0 : check_upd;
    end

    // Output register: load on accept, empty when taken with nothing new.
    always_comb
    begin
        priority if (accept)
            out_valid_next = 1'b1;
        else if (parsed.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ver_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            cmd_reg       <= '0;
            len_reg       <= '0;
            check_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg <= state_next;
                ver_reg   <= ver_next;
                dir_reg   <= dir_next;
                cmd_reg   <= cmd_next;
                len_reg   <= len_next;
                check_reg <= check_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign parsed.valid         = out_valid_reg;
    assign parsed.status        = res_reg.status;
    assign parsed.payload_valid = res_reg.payload_valid;
    assign parsed.payload_byte  = res_reg.payload_byte;
    assign parsed.payload_index = res_reg.payload_index;
    assign parsed.command       = res_reg.command;
    assign parsed.length        = res_reg.length;
    assign parsed.direction     = res_reg.direction;
    assign parsed.version       = res_reg.version;

    `MSP_FP_ASSERT_NOW(a_payload_in_progress, clk, rst_n, out_valid_reg && res_reg.payload_valid, res_reg.status == STATUS_PROGRESS, "payload byte reported with a final status")
    `MSP_FP_ASSERT_NOW(a_non_payload_zero, clk, rst_n, out_valid_reg && !res_reg.payload_valid, res_reg.payload_byte == '0 && res_reg.payload_index == '0, "payload fields not zero outside payload")
    `MSP_FP_ASSERT_NOW(a_count_below_length, clk, rst_n, state_reg == ST_PAYLOAD, cnt_reg < len_reg, "payload counter ran past the frame length")
    `MSP_FP_ASSERT_NOW(a_v2_length_bound, clk, rst_n, state_reg == ST_PAYLOAD && ver_reg, len_reg <= MAX_LEN, "v2 payload above the length limit")
    `MSP_FP_ASSERT_NEXT(a_good_clears, clk, rst_n, accept && good, state_reg == ST_IDLE && cmd_reg == '0 && len_reg == '0 && check_reg == '0, "frame fields not cleared after a good frame")

endmodule

`default_nettype wire
